[src/rrpg_pkg.sv]
package rrpg_pkg;

  localparam int DIM_W   = 13;
  localparam int TIME_W  = 24;
  localparam int GRAY_W  = 8;
  localparam int ADDR_W  = 3;
  localparam int DATA_W  = 32;

  typedef logic [DIM_W-1:0] dim_t;

  localparam dim_t MAX_DIM    = 13'd4096;
  localparam dim_t WIDTH_RST  = 13'd640;
  localparam dim_t HEIGHT_RST = 13'd480;

  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  localparam int OFS_W   = DIM_W + 1;
  localparam int SQR_W   = 2 * OFS_W;
  localparam int SQ_IN_W = 44;
  localparam int SQ_BITS = 22;
  localparam int SQ_TW   = 46;

  localparam logic [33:0] KD     = 34'd8749635527;
  localparam logic [34:0] KT     = 35'd24998958650;
  localparam logic [31:0] PI_Q30 = 32'd3373259426;

  localparam int DV_W = SQ_BITS + 1;
  localparam logic [DV_W-1:0] DEN_BASE  = 23'd5120;
  localparam logic [19:0]     NUM_SCALE = 20'd650240;

  localparam int Q_W = 30;
  localparam int C_W = 31;
  localparam logic [C_W-1:0] ONE_Q30 = 31'h4000_0000;

  localparam int HORNER = 4;

  localparam logic [31:0] M_C0 = 32'(((64'd1 << 36) + 64'd55) / 64'd56);
  localparam logic [31:0] M_C1 = 32'(((64'd1 << 35) + 64'd29) / 64'd30);
  localparam logic [31:0] M_C2 = 32'(((64'd1 << 34) + 64'd11) / 64'd12);
  localparam logic [31:0] M_C3 = 32'(((64'd1 << 31) + 64'd1) / 64'd2);
  localparam logic [31:0] M_S0 = 32'(((64'd1 << 37) + 64'd71) / 64'd72);
  localparam logic [31:0] M_S1 = 32'(((64'd1 << 36) + 64'd41) / 64'd42);
  localparam logic [31:0] M_S2 = 32'(((64'd1 << 35) + 64'd19) / 64'd20);
  localparam logic [31:0] M_S3 = 32'(((64'd1 << 33) + 64'd5) / 64'd6);

  localparam logic [31:0] COS_M [HORNER] = '{M_C0, M_C1, M_C2, M_C3};
  localparam logic [5:0]  COS_S [HORNER] = '{6'd36, 6'd35, 6'd34, 6'd31};
  localparam logic [31:0] SIN_M [HORNER] = '{M_S0, M_S1, M_S2, M_S3};
  localparam logic [5:0]  SIN_S [HORNER] = '{6'd37, 6'd36, 6'd35, 6'd33};

  typedef struct packed {
    logic [1:0] quad;
    logic       rneg;
  } quad_t;

  function automatic dim_t sat_dim(input dim_t v);
    return (v > MAX_DIM) ? MAX_DIM : v;
  endfunction

  function automatic logic [OFS_W-1:0] abs_diff2(input dim_t coord, input dim_t dim);
    logic [OFS_W-1:0] a;
    logic [OFS_W-1:0] b;
    a = {coord, 1'b0};
    b = {1'b0, dim};
    return (a >= b) ? a - b : b - a;
  endfunction

  function automatic logic [Q_W-1:0] rdiv(input logic [Q_W-1:0] n, input logic [31:0] m,
                                          input logic [5:0] sh);
    logic [61:0] prod;
    prod = {32'b0, n} * {30'b0, m};
    return Q_W'(prod >> sh);
  endfunction

  function automatic logic [Q_W-1:0] mulq(input logic [Q_W-1:0] a, input logic [C_W-1:0] b);
    logic [60:0] prod;
    prod = {31'b0, a} * {30'b0, b};
    return prod[59:30];
  endfunction

endpackage

[src/rrpg_pixel_if.sv]
interface rrpg_pixel_if;
  import rrpg_pkg::*;

  logic              valid;
  logic              ready;
  logic [DIM_W-1:0]  pixel_row;
  logic [DIM_W-1:0]  pixel_col;
  logic [TIME_W-1:0] frame_time;

  modport source (output valid, pixel_row, pixel_col, frame_time, input ready);
  modport sink (input valid, pixel_row, pixel_col, frame_time, output ready);
endinterface

[src/rrpg_gray_if.sv]
interface rrpg_gray_if;
  import rrpg_pkg::*;

  logic              valid;
  logic              ready;
  logic [GRAY_W-1:0] gray_level;

  modport source (output valid, gray_level, input ready);
  modport sink (input valid, gray_level, output ready);
endinterface

[src/radial_ripple_pixel_generator_core.sv]
// Channel   Dir  Payload                               Transfer
// pixel     in   pixel_row, pixel_col, frame_time      valid & ready
// result    out  gray_level                            valid & ready
// apb       in   image_width (0x0), image_height (0x4) psel & penable & pwrite
//
// One pixel per cycle while the skid register is empty.
// The pipeline holds the 22-stage square root, the Horner cosine/sine stages
// and the 8-stage quotient, all one register stage each.
// rst is synchronous, clears the valid bits and loads the reset dimensions.
// A skid register behind the output register holds one result; the pipeline
// freezes only while that skid register is full.
module radial_ripple_pixel_generator_core (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [rrpg_pkg::ADDR_W-1:0] paddr,
  input  logic [rrpg_pkg::DATA_W-1:0] pwdata,
  output logic [rrpg_pkg::DATA_W-1:0] prdata,
  output logic                     pready,
  rrpg_pixel_if.sink               pixel,
  rrpg_gray_if.source              result
);
  import rrpg_pkg::*;

  localparam int NST = 49;

  dim_t image_width;
  dim_t image_height;
  logic en;
  logic [NST:1] vld;

  logic [OFS_W-1:0] fx1, fy1;
  logic [40:0]      th1;
  logic [41:0]      tl1;
  logic [SQR_W-1:0] fx2, fy2;
  logic [31:0]      tt [2:27];
  logic [59:0]      tsum;

  logic [SQ_IN_W-1:0] sq_rem   [0:SQ_BITS];
  logic [SQ_BITS-1:0] sq_root  [0:SQ_BITS];
  logic [SQ_TW-1:0]   sq_trial [0:SQ_BITS-1];

  logic [38:0]     dh26, dl26;
  logic [DV_W-1:0] dv [26:48];
  logic [56:0]     dsum;
  logic [31:0]     td27;
  logic [31:0]     u_n;
  quad_t           qr [28:38];
  logic [Q_W-1:0]  mag28;
  logic [61:0]     xprod;
  logic [Q_W-1:0]  xd  [29:37];
  logic [Q_W-1:0]  x2d [30:35];
  logic [C_W-1:0]  hc [0:HORNER-1];
  logic [C_W-1:0]  hs [0:HORNER-1];
  logic [Q_W-1:0]  htc [1:HORNER-1];
  logic [Q_W-1:0]  hts [1:HORNER-1];
  logic [C_W-1:0]  cos38, sin38, cmag39;
  logic            neg_n;
  logic [48:39]    negd;

  logic [50:0] dr [0:8];
  logic [7:0]  dq [0:8];
  logic [59:0] dtrial [0:7];

  logic              up;
  logic signed [9:0] gs;
  logic [GRAY_W-1:0] g_n, g49;

  logic              out_v, skid_v;
  logic [GRAY_W-1:0] out_d, skid_d;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_HEIGHT) ? {{(DATA_W-DIM_W){1'b0}}, image_height}
                                           : {{(DATA_W-DIM_W){1'b0}}, image_width};

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= WIDTH_RST;
      image_height <= HEIGHT_RST;
    end else if (psel && penable && pwrite && pready) begin
      unique case (paddr[2])
        REG_WIDTH:  image_width  <= pwdata[DIM_W-1:0];
        REG_HEIGHT: image_height <= pwdata[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  assign en          = !skid_v;
  assign pixel.ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NST-1:1], pixel.valid};
    end
  end

  always_comb begin
    tsum  = ({19'b0, th1} << 18) + {18'b0, tl1};
    dsum  = ({18'b0, dh26} << 17) + {18'b0, dl26};
    u_n   = td27 - tt[27] + 32'h2000_0000;
    xprod = {32'b0, mag28} * {30'b0, PI_Q30};
    for (int j = 0; j < SQ_BITS; j++) begin
      sq_trial[j] = ({{(SQ_TW-SQ_BITS){1'b0}}, sq_root[j]} << (SQ_BITS - j))
                  | (SQ_TW'(1) << (2 * (SQ_BITS - 1 - j)));
    end
    for (int k = 0; k < 8; k++) begin
      dtrial[k] = {{(60-DV_W){1'b0}}, dv[40+k]} << (37 - k);
    end
    case (qr[38].quad)
      2'd0:    neg_n = 1'b0;
      2'd1:    neg_n = !qr[38].rneg;
      2'd2:    neg_n = 1'b1;
      default: neg_n = qr[38].rneg;
    endcase
  end

  always_comb begin
    up = dr[8] >= {{(51-DV_W){1'b0}}, dv[48]};
    if (negd[48]) begin
      gs = 10'sd128 - $signed({2'b0, dq[8]}) - $signed({9'b0, up});
    end else begin
      gs = 10'sd128 + $signed({2'b0, dq[8]});
    end
    if (gs < 10'sd0) begin
      g_n = '0;
    end else if (gs > 10'sd255) begin
      g_n = '1;
    end else begin
      g_n = gs[GRAY_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fx1 <= abs_diff2(sat_dim(pixel.pixel_row), sat_dim(image_height));
      fy1 <= abs_diff2(sat_dim(pixel.pixel_col), sat_dim(image_width));
      th1 <= {17'b0, pixel.frame_time} * {24'b0, KT[34:18]};
      tl1 <= {18'b0, pixel.frame_time} * {24'b0, KT[17:0]};

      fx2   <= {{OFS_W{1'b0}}, fx1} * {{OFS_W{1'b0}}, fx1};
      fy2   <= {{OFS_W{1'b0}}, fy1} * {{OFS_W{1'b0}}, fy1};
      tt[2] <= tsum[47:16];
      for (int k = 3; k <= 27; k++) begin
        tt[k] <= tt[k-1];
      end

      sq_rem[0]  <= {fx2 + fy2, 16'b0};
      sq_root[0] <= '0;
      for (int j = 0; j < SQ_BITS; j++) begin
        if ({2'b0, sq_rem[j]} >= sq_trial[j]) begin
          sq_rem[j+1]  <= sq_rem[j] - sq_trial[j][SQ_IN_W-1:0];
          sq_root[j+1] <= sq_root[j] | (SQ_BITS'(1) << (SQ_BITS - 1 - j));
        end else begin
          sq_rem[j+1]  <= sq_rem[j];
          sq_root[j+1] <= sq_root[j];
        end
      end

      dh26   <= {17'b0, sq_root[SQ_BITS]} * {22'b0, KD[33:17]};
      dl26   <= {17'b0, sq_root[SQ_BITS]} * {22'b0, KD[16:0]};
      dv[26] <= {1'b0, sq_root[SQ_BITS]} + DEN_BASE;
      for (int k = 27; k <= 48; k++) begin
        dv[k] <= dv[k-1];
      end

      td27 <= dsum[47:16];

      qr[28].quad <= u_n[31:30];
      qr[28].rneg <= !u_n[29];
      mag28       <= u_n[29] ? {1'b0, u_n[28:0]} : 30'h2000_0000 - u_n[29:0];
      for (int k = 29; k <= 38; k++) begin
        qr[k] <= qr[k-1];
      end

      xd[29] <= xprod[60:31];
      for (int k = 30; k <= 37; k++) begin
        xd[k] <= xd[k-1];
      end
      x2d[30] <= mulq(xd[29], {1'b0, xd[29]});
      for (int k = 31; k <= 35; k++) begin
        x2d[k] <= x2d[k-1];
      end

      hc[0] <= ONE_Q30 - {1'b0, rdiv(x2d[30], COS_M[0], COS_S[0])};
      hs[0] <= ONE_Q30 - {1'b0, rdiv(x2d[30], SIN_M[0], SIN_S[0])};
      for (int j = 1; j < HORNER; j++) begin
        htc[j] <= mulq(x2d[29+2*j], hc[j-1]);
        hts[j] <= mulq(x2d[29+2*j], hs[j-1]);
        hc[j]  <= ONE_Q30 - {1'b0, rdiv(htc[j], COS_M[j], COS_S[j])};
        hs[j]  <= ONE_Q30 - {1'b0, rdiv(hts[j], SIN_M[j], SIN_S[j])};
      end

      cos38 <= hc[HORNER-1];
      sin38 <= {1'b0, mulq(xd[37], hs[HORNER-1])};

      cmag39   <= qr[38].quad[0] ? sin38 : cos38;
      negd[39] <= neg_n;
      for (int k = 40; k <= 48; k++) begin
        negd[k] <= negd[k-1];
      end

      dr[0] <= {31'b0, NUM_SCALE} * {20'b0, cmag39};
      dq[0] <= '0;
      for (int k = 0; k < 8; k++) begin
        if ({9'b0, dr[k]} >= dtrial[k]) begin
          dr[k+1] <= dr[k] - dtrial[k][50:0];
          dq[k+1] <= dq[k] | (8'd1 << (7 - k));
        end else begin
          dr[k+1] <= dr[k];
          dq[k+1] <= dq[k];
        end
      end

      g49 <= g_n;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_v  <= 1'b0;
      skid_v <= 1'b0;
    end else if (!out_v || result.ready) begin
      if (skid_v) begin
        out_v  <= 1'b1;
        out_d  <= skid_d;
        skid_v <= 1'b0;
      end else begin
        out_v <= vld[NST];
        out_d <= g49;
      end
    end else if (vld[NST] && en) begin
      skid_v <= 1'b1;
      skid_d <= g49;
    end
  end

  assign result.valid      = out_v;
  assign result.gray_level = out_d;

  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst) skid_v |-> out_v)
    else $error("skid register full while output register empty");

  a_freeze: assert property (@(posedge clk) disable iff (rst) !en |=> vld == $past(vld))
    else $error("pipeline valid bits moved during stall");

  a_quot_range: assert property (@(posedge clk) disable iff (rst) vld[48] |-> !dq[8][7])
    else $error("ripple quotient out of range");

endmodule
